@@ rtl/core/max_heap_build_and_increase_key_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the max-heap unit
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_BUILD_AND_INCREASE_KEY_UNIT_DEFINES_SVH
`define MAX_HEAP_BUILD_AND_INCREASE_KEY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MHBIK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MHBIK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MHBIK_ASSERT_NOW(lbl, ante, cons, msg)
`define MHBIK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/mhbik_pkg.sv @@
// ----------------------------------------------------------------------------
// Max-heap unit package
// Operation, status and datapath action codes, and the controller links.
// ----------------------------------------------------------------------------
package mhbik_pkg;

    localparam int KEY_W  = 32;
    localparam int POS_W  = 11;
    localparam int SIZE_W = 11;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int ACT_W  = 4;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_INCR  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_LARGER = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE      = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CAPTURE    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE_KEY  = 4'd2;
    localparam logic [ACT_W-1:0] ACT_READ_CUR   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_TAKE_READ  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_READ_PAR   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_SU_STEP    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_BUILD_INIT = 4'd7;
    localparam logic [ACT_W-1:0] ACT_SD_START   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_SD_KEY     = 4'd9;
    localparam logic [ACT_W-1:0] ACT_READ_LEFT  = 4'd10;
    localparam logic [ACT_W-1:0] ACT_SD_LEFT    = 4'd11;
    localparam logic [ACT_W-1:0] ACT_SD_DEC     = 4'd12;
    localparam logic [ACT_W-1:0] ACT_DEC_I      = 4'd13;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              publish;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pos_bad;
        logic            key_gt_rd;
        logic            is_root;
        logic            left_out;
        logic            sift_stop;
        logic            i_zero;
    } t_dp_flags;

endpackage

@@ rtl/core/mhbik_dp.sv @@
// ----------------------------------------------------------------------------
// Max-heap datapath
// Key store, position and key registers, compares and the result registers.
// ----------------------------------------------------------------------------
module mhbik_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [mhbik_pkg::SIZE_W-1:0]       i_cfg_wr_data,
    input  logic [mhbik_pkg::OP_W-1:0]         i_operation,
    input  logic [mhbik_pkg::POS_W-1:0]        i_position,
    input  logic signed [mhbik_pkg::KEY_W-1:0] i_key,
    input  mhbik_pkg::t_dp_cmd                 i_cmd,
    output mhbik_pkg::t_dp_flags               o_flags,
    output logic [mhbik_pkg::STAT_W-1:0]       o_status,
    output logic signed [mhbik_pkg::KEY_W-1:0] o_read_key
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > mhbik_pkg::SIZE_W) ? PW : mhbik_pkg::SIZE_W;

    logic [mhbik_pkg::KEY_W-1:0] mem [CAPACITY];

    logic [mhbik_pkg::SIZE_W-1:0] r_heap_size;
    logic [mhbik_pkg::OP_W-1:0]   r_op;
    logic [mhbik_pkg::POS_W-1:0]  r_pos;
    logic [PW-1:0]                r_cur;
    logic [PW-1:0]                r_i;
    logic [PW-1:0]                r_best;
    logic                         r_best_is_node;
    logic                         r_right_ok;
    logic signed [mhbik_pkg::KEY_W-1:0] r_k;
    logic signed [mhbik_pkg::KEY_W-1:0] r_bk;
    logic signed [mhbik_pkg::KEY_W-1:0] r_rdata;
    logic [mhbik_pkg::STAT_W-1:0] r_pend_status;
    logic signed [mhbik_pkg::KEY_W-1:0] r_pend_key;
    logic [mhbik_pkg::STAT_W-1:0] r_out_status;
    logic signed [mhbik_pkg::KEY_W-1:0] r_out_key;

    logic [CW-1:0] hs_ext;
    logic [CW-1:0] n_full;
    logic [CW-1:0] pos_ext;
    logic [PW-1:0] n;
    logic [PW:0]   left_full;
    logic [PW:0]   right_full;
    logic [PW-1:0] left_pos;
    logic [PW-1:0] right_pos;
    logic          right_ok;
    logic          k_gt_rd;
    logic          rd_gt_k;
    logic          take_right;
    logic          sift_stop;
    logic signed [mhbik_pkg::KEY_W-1:0] best_key;

    logic                         mem_we;
    logic [PW-1:0]                mem_wpos;
    logic [PW-1:0]                wpos_m1;
    logic [mhbik_pkg::KEY_W-1:0]  mem_wdata;
    logic                         mem_re;
    logic [PW-1:0]                mem_rpos;
    logic [PW-1:0]                rpos_m1;

    assign hs_ext     = CW'(r_heap_size);
    assign n_full     = (hs_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : hs_ext;
    assign n          = n_full[PW-1:0];
    assign pos_ext    = CW'(i_position);
    assign left_full  = {r_cur, 1'b0};
    assign right_full = {r_cur, 1'b1};
    assign left_pos   = left_full[PW-1:0];
    assign right_pos  = right_full[PW-1:0];
    assign right_ok   = right_full <= (PW + 1)'(n);
    assign k_gt_rd    = r_k > r_rdata;
    assign rd_gt_k    = r_rdata > r_k;
    assign take_right = r_right_ok && (r_rdata > r_bk);
    assign sift_stop  = !take_right && r_best_is_node;
    assign best_key   = take_right ? r_rdata : r_bk;

    always_comb begin
        o_flags.op        = r_op;
        o_flags.pos_bad   = (r_pos == '0) || (CW'(r_pos) > CW'(n));
        o_flags.key_gt_rd = k_gt_rd;
        o_flags.is_root   = r_cur == PW'(1);
        o_flags.left_out  = left_full > (PW + 1)'(n);
        o_flags.sift_stop = sift_stop;
        o_flags.i_zero    = r_i == '0;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wpos  = r_cur;
        mem_wdata = r_k;
        mem_re    = 1'b0;
        mem_rpos  = r_cur;
        unique case (i_cmd.act)
            mhbik_pkg::ACT_WRITE_KEY: begin
                mem_we = 1'b1;
            end
            mhbik_pkg::ACT_READ_CUR: begin
                mem_re = 1'b1;
            end
            mhbik_pkg::ACT_READ_PAR: begin
                mem_re   = 1'b1;
                mem_rpos = r_cur >> 1;
            end
            mhbik_pkg::ACT_SU_STEP: begin
                mem_we    = 1'b1;
                mem_wdata = k_gt_rd ? r_rdata : r_k;
            end
            mhbik_pkg::ACT_SD_START: begin
                mem_re   = 1'b1;
                mem_rpos = r_i;
            end
            mhbik_pkg::ACT_READ_LEFT: begin
                mem_re   = 1'b1;
                mem_rpos = left_pos;
            end
            mhbik_pkg::ACT_SD_LEFT: begin
                mem_re   = right_ok;
                mem_rpos = right_pos;
            end
            mhbik_pkg::ACT_SD_DEC: begin
                mem_we    = 1'b1;
                mem_wdata = sift_stop ? r_k : best_key;
            end
            default: begin
            end
        endcase
    end

    assign wpos_m1 = mem_wpos - PW'(1);
    assign rpos_m1 = mem_rpos - PW'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wpos_m1[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[rpos_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_size <= '0;
        end else if (i_cfg_wr_en) begin
            r_heap_size <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            mhbik_pkg::ACT_CAPTURE: begin
                r_op       <= i_operation;
                r_pos      <= i_position;
                r_cur      <= pos_ext[PW-1:0];
                r_k        <= i_key;
                r_pend_key <= '0;
            end
            mhbik_pkg::ACT_TAKE_READ: begin
                r_pend_key <= r_rdata;
            end
            mhbik_pkg::ACT_SU_STEP: begin
                if (k_gt_rd) begin
                    r_cur <= r_cur >> 1;
                end
            end
            mhbik_pkg::ACT_BUILD_INIT: begin
                r_i <= n >> 1;
            end
            mhbik_pkg::ACT_SD_START: begin
                r_cur <= r_i;
            end
            mhbik_pkg::ACT_SD_KEY: begin
                r_k <= r_rdata;
            end
            mhbik_pkg::ACT_SD_LEFT: begin
                r_right_ok <= right_ok;
                if (rd_gt_k) begin
                    r_bk           <= r_rdata;
                    r_best         <= left_pos;
                    r_best_is_node <= 1'b0;
                end else begin
                    r_bk           <= r_k;
                    r_best         <= r_cur;
                    r_best_is_node <= 1'b1;
                end
            end
            mhbik_pkg::ACT_SD_DEC: begin
                if (!sift_stop) begin
                    r_cur <= take_right ? right_pos : r_best;
                end
            end
            mhbik_pkg::ACT_DEC_I: begin
                r_i <= r_i - PW'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.set_status) begin
            r_pend_status <= i_cmd.status;
        end
        if (i_cmd.publish) begin
            r_out_status <= r_pend_status;
            r_out_key    <= r_pend_key;
        end
    end

    assign o_status   = r_out_status;
    assign o_read_key = r_out_key;

endmodule

@@ rtl/core/mhbik_ctrl.sv @@
// ----------------------------------------------------------------------------
// Max-heap controller
// Sequences each operation as datapath actions and owns both handshakes.
// ----------------------------------------------------------------------------
`include "max_heap_build_and_increase_key_unit_defines.svh"

module mhbik_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  mhbik_pkg::t_dp_flags i_flags,
    output mhbik_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_RWAIT    = 4'd2;
    localparam logic [3:0] S_SU       = 4'd3;
    localparam logic [3:0] S_SU_CMP   = 4'd4;
    localparam logic [3:0] S_B_CHECK  = 4'd5;
    localparam logic [3:0] S_SD_KEY   = 4'd6;
    localparam logic [3:0] S_SD_CHILD = 4'd7;
    localparam logic [3:0] S_SD_LEFT  = 4'd8;
    localparam logic [3:0] S_SD_DEC   = 4'd9;
    localparam logic [3:0] S_B_NEXT   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd.act        = mhbik_pkg::ACT_NONE;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = mhbik_pkg::ST_OK;
        o_cmd.publish    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.act = mhbik_pkg::ACT_CAPTURE;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                if (i_flags.op == mhbik_pkg::OP_BUILD) begin
                    o_cmd.act = mhbik_pkg::ACT_BUILD_INIT;
                    n_state   = S_B_CHECK;
                end else if (i_flags.pos_bad) begin
                    o_cmd.status = mhbik_pkg::ST_RANGE;
                    n_state      = S_DONE;
                end else if (i_flags.op == mhbik_pkg::OP_LOAD) begin
                    o_cmd.act = mhbik_pkg::ACT_WRITE_KEY;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.act = mhbik_pkg::ACT_READ_CUR;
                    n_state   = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (i_flags.op == mhbik_pkg::OP_READ) begin
                    o_cmd.act = mhbik_pkg::ACT_TAKE_READ;
                    n_state   = S_DONE;
                end else if (!i_flags.key_gt_rd) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = mhbik_pkg::ST_NOT_LARGER;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_SU;
                end
            end
            S_SU: begin
                if (i_flags.is_root) begin
                    o_cmd.act = mhbik_pkg::ACT_WRITE_KEY;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.act = mhbik_pkg::ACT_READ_PAR;
                    n_state   = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                o_cmd.act = mhbik_pkg::ACT_SU_STEP;
                n_state   = i_flags.key_gt_rd ? S_SU : S_DONE;
            end
            S_B_CHECK: begin
                if (i_flags.i_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.act = mhbik_pkg::ACT_SD_START;
                    n_state   = S_SD_KEY;
                end
            end
            S_SD_KEY: begin
                o_cmd.act = mhbik_pkg::ACT_SD_KEY;
                n_state   = S_SD_CHILD;
            end
            S_SD_CHILD: begin
                if (i_flags.left_out) begin
                    o_cmd.act = mhbik_pkg::ACT_WRITE_KEY;
                    n_state   = S_B_NEXT;
                end else begin
                    o_cmd.act = mhbik_pkg::ACT_READ_LEFT;
                    n_state   = S_SD_LEFT;
                end
            end
            S_SD_LEFT: begin
                o_cmd.act = mhbik_pkg::ACT_SD_LEFT;
                n_state   = S_SD_DEC;
            end
            S_SD_DEC: begin
                o_cmd.act = mhbik_pkg::ACT_SD_DEC;
                n_state   = i_flags.sift_stop ? S_B_NEXT : S_SD_CHILD;
            end
            S_B_NEXT: begin
                o_cmd.act = mhbik_pkg::ACT_DEC_I;
                n_state   = S_B_CHECK;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `MHBIK_ASSERT_NOW(a_publish_slot_free, o_cmd.publish, slot_free, "result published over a pending transfer")
    `MHBIK_ASSERT_NEXT(a_done_drains, (r_state == S_DONE) && slot_free, (r_state == S_IDLE) && r_out_valid, "finished item did not reach the output")
    `MHBIK_ASSERT_NOW(a_su_cmp_after_read, r_state == S_SU_CMP, $past(r_state) == S_SU, "parent compare without a parent read")

endmodule

@@ rtl/core/max_heap_build_and_increase_key_unit.sv @@
// ----------------------------------------------------------------------------
// Max-heap build and increase-key unit
// One-based binary max-heap of signed keys with load, build, increase, read.
// ----------------------------------------------------------------------------
// Channel     Direction  Contents
// s_axis      in         operation, position, key
// m_axis      out        status, read_key
// cfg         in         heap_size write
//
// Load and out-of-range items go from decode straight to the output stage; read
// and a rejected increase first read the key. Increase-key climbs towards the
// root, each level one read and one write. Build sifts down every inner node from
// the last to the root, each level one read per child and one write.
// Reset clears control and heap_size, not the store.
// A stalled output holds its result while the next item is already at work.
// ----------------------------------------------------------------------------
module max_heap_build_and_increase_key_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // operation [1:0], position [12:2], key [44:13], zero fill [47:45]
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status [1:0], read_key [33:2], zero fill [39:34]
    output logic [39:0] o_m_axis_tdata
);

    mhbik_pkg::t_dp_cmd   cmd;
    mhbik_pkg::t_dp_flags flags;

    logic [mhbik_pkg::STAT_W-1:0]       status;
    logic signed [mhbik_pkg::KEY_W-1:0] read_key;

    mhbik_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    mhbik_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_operation   (i_s_axis_tdata[1:0]),
        .i_position    (i_s_axis_tdata[12:2]),
        .i_key         (i_s_axis_tdata[44:13]),
        .i_cmd         (cmd),
        .o_flags       (flags),
        .o_status      (status),
        .o_read_key    (read_key)
    );

    assign o_m_axis_tdata = {6'd0, read_key, status};

endmodule

@@ sim/heap_result_checker.sv @@
// ----------------------------------------------------------------------------
// Max-heap result checker
// Watches the configuration port and both stream channels, keeps its own copy
// of the heap keys and heap size, works out the status and read key of every
// accepted operation, and compares each result transfer with the oldest
// expected result. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module heap_result_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // operation [1:0], position [12:2], key [44:13], zero fill [47:45]
    input  logic [47:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // status [1:0], read_key [33:2], zero fill [39:34]
    input  logic [39:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mhbik_pkg::STAT_W-1:0] status;
        logic [mhbik_pkg::KEY_W-1:0]  read_key;
    } t_heap_result;

    logic signed [mhbik_pkg::KEY_W-1:0] heap_keys [1:CAPACITY];
    logic [mhbik_pkg::SIZE_W-1:0]       heap_size = '0;
    t_heap_result                       expected_results [$];

    function automatic t_heap_result apply_heap_op(
        input logic [mhbik_pkg::OP_W-1:0]         op,
        input logic [mhbik_pkg::POS_W-1:0]        pos,
        input logic signed [mhbik_pkg::KEY_W-1:0] key
    );
        t_heap_result                       res;
        int                                 n;
        int                                 i;
        int                                 node;
        int                                 best;
        int                                 p;
        bit                                 moved;
        logic signed [mhbik_pkg::KEY_W-1:0] tmp;
        res.status   = mhbik_pkg::ST_OK;
        res.read_key = '0;
        n = (heap_size > CAPACITY) ? CAPACITY : int'(heap_size);
        p = int'(pos);
        if (op == mhbik_pkg::OP_BUILD) begin
            for (i = n / 2; i >= 1; i--) begin
                node  = i;
                moved = 1'b1;
                while (moved) begin
                    best = node;
                    if (2 * node <= n && heap_keys[2 * node] > heap_keys[best]) begin
                        best = 2 * node;
                    end
                    if (2 * node + 1 <= n && heap_keys[2 * node + 1] > heap_keys[best]) begin
                        best = 2 * node + 1;
                    end
                    moved = (best != node);
                    if (moved) begin
                        tmp             = heap_keys[node];
                        heap_keys[node] = heap_keys[best];
                        heap_keys[best] = tmp;
                        node            = best;
                    end
                end
            end
        end else if (p < 1 || p > n) begin
            res.status = mhbik_pkg::ST_RANGE;
        end else if (op == mhbik_pkg::OP_LOAD) begin
            heap_keys[p] = key;
        end else if (op == mhbik_pkg::OP_READ) begin
            res.read_key = heap_keys[p];
        end else if (!(key > heap_keys[p])) begin
            res.status = mhbik_pkg::ST_NOT_LARGER;
        end else begin
            heap_keys[p] = key;
            while (p > 1 && heap_keys[p] > heap_keys[p / 2]) begin
                tmp              = heap_keys[p];
                heap_keys[p]     = heap_keys[p / 2];
                heap_keys[p / 2] = tmp;
                p                = p / 2;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result want;
        t_heap_result got;
        if (!i_rst_n) begin
            heap_size = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                heap_size = i_cfg_wr_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(apply_heap_op(i_s_tdata[1:0], i_s_tdata[12:2],
                                                         i_s_tdata[44:13]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status   = i_m_tdata[1:0];
                got.read_key = i_m_tdata[33:2];
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual status %0d read_key %h",
                             $time, got.status, got.read_key);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t ns: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.read_key != want.read_key) begin
                        $display("%0t ns: read_key mismatch, expected %h, actual %h",
                                 $time, want.read_key, got.read_key);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Max-heap unit testbench
// Drives load, build, increase-key and read operations over a series of heap
// sizes, from a short directed sequence to filled heaps with random traffic,
// with bursty input, a stalling output and two long output hold-offs. The
// checker beside the block predicts every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY       = 1024;
    localparam int FILL_MAX       = 64;
    localparam int NUM_PHASES     = 16;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 8000;
    localparam int TAIL_CYCLES    = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          fail_count;
    int          results_pending;

    int                           burst_left = 0;
    bit                           loaded [1:CAPACITY];
    logic [mhbik_pkg::SIZE_W-1:0] heap_size_now = '0;
    bit                           hold_toggle = 1'b0;
    int                           quiet_cycles = 0;
    int                           phase_sizes [NUM_PHASES] =
        '{5, 1, 2, 3, 16, 33, 64, 9, 0, 2047, 1024, 12, 63, 7, 21, 40};

    always #1 clk = ~clk;

    max_heap_build_and_increase_key_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    heap_result_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    function automatic int eff_size();
        return (heap_size_now > CAPACITY) ? CAPACITY : int'(heap_size_now);
    endfunction

    // An increase may swap with any ancestor, so the whole path must hold keys.
    function automatic bit path_loaded(input int pos);
        int p;
        p = pos;
        while (p >= 1) begin
            if (!loaded[p]) begin
                return 1'b0;
            end
            p = p / 2;
        end
        return 1'b1;
    endfunction

    function automatic bit all_loaded(input int n);
        int p;
        for (p = 1; p <= n; p++) begin
            if (!loaded[p]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [mhbik_pkg::KEY_W-1:0] gen_key();
        case ($urandom_range(0, 5))
            0, 1: begin
                return $urandom_range(0, 6) - 3;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    task automatic send_item(input logic [mhbik_pkg::OP_W-1:0] op,
                             input logic [mhbik_pkg::POS_W-1:0] pos,
                             input logic [mhbik_pkg::KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, key, pos, op};
        do @(posedge clk); while (!s_tready);
        if (op == mhbik_pkg::OP_LOAD && pos >= 1 && pos <= eff_size()) begin
            loaded[pos] = 1'b1;
        end
        burst_left = burst_left - 1;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (results_pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic set_heap_size(input logic [mhbik_pkg::SIZE_W-1:0] size);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        heap_size_now = size;
    endtask

    // Output side: changing ready patterns, plus a long hold-off on request.
    initial begin
        bit hold_seen;
        int ready_mode;
        int mode_left;
        hold_seen  = 1'b0;
        ready_mode = 0;
        mode_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left = mode_left - 1;
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                             n;
        int                             lim;
        int                             ph;
        int                             k;
        int                             p;
        int                             roll;
        logic [mhbik_pkg::OP_W-1:0]     op;
        logic [mhbik_pkg::KEY_W-1:0]    key;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        set_heap_size(11'd8);
        send_item(mhbik_pkg::OP_LOAD, 11'd1, -32'sd7);
        send_item(mhbik_pkg::OP_LOAD, 11'd2, 32'd5);
        send_item(mhbik_pkg::OP_LOAD, 11'd3, 32'h8000_0000);
        send_item(mhbik_pkg::OP_LOAD, 11'd4, 32'd5);
        send_item(mhbik_pkg::OP_LOAD, 11'd5, 32'd0);
        send_item(mhbik_pkg::OP_LOAD, 11'd6, 32'h7fff_ffff);
        send_item(mhbik_pkg::OP_LOAD, 11'd7, 32'hffff_ffff);
        send_item(mhbik_pkg::OP_LOAD, 11'd8, 32'd1);
        send_item(mhbik_pkg::OP_BUILD, 11'd0, 32'd0);
        send_item(mhbik_pkg::OP_READ, 11'd1, 32'd0);
        send_item(mhbik_pkg::OP_READ, 11'd8, 32'd0);
        send_item(mhbik_pkg::OP_INCR, 11'd8, 32'h8000_0000);
        send_item(mhbik_pkg::OP_INCR, 11'd8, 32'h7fff_ffff);
        send_item(mhbik_pkg::OP_INCR, 11'd1, 32'h7fff_ffff);
        send_item(mhbik_pkg::OP_READ, 11'd2, 32'd0);
        send_item(mhbik_pkg::OP_READ, 11'd4, 32'd0);
        send_item(mhbik_pkg::OP_READ, 11'd0, 32'd0);
        send_item(mhbik_pkg::OP_READ, 11'd9, 32'd0);
        send_item(mhbik_pkg::OP_LOAD, 11'd0, 32'h1234_5678);
        send_item(mhbik_pkg::OP_INCR, 11'd2047, 32'h7fff_ffff);
        send_item(mhbik_pkg::OP_READ, 11'd2047, 32'd0);
        send_item(mhbik_pkg::OP_BUILD, 11'd2047, 32'hffff_ffff);
        send_item(mhbik_pkg::OP_READ, 11'd1, 32'd0);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_heap_size(11'(phase_sizes[ph]));
            n   = eff_size();
            lim = (n < FILL_MAX) ? n : FILL_MAX;
            for (p = 1; p <= lim; p++) begin
                if (!loaded[p]) begin
                    send_item(mhbik_pkg::OP_LOAD, p[10:0], gen_key());
                end
            end
            if (all_loaded(n)) begin
                send_item(mhbik_pkg::OP_BUILD, 11'd0, 32'd0);
            end
            if (ph == 4 || ph == 11) begin
                hold_toggle <= ~hold_toggle;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                roll = $urandom_range(0, 99);
                key  = gen_key();
                if (n == 0 || roll < 6) begin
                    op = 2'($urandom_range(0, 3));
                    p  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(n + 1, 2047);
                    if (op == mhbik_pkg::OP_BUILD && !all_loaded(n)) begin
                        op = mhbik_pkg::OP_LOAD;
                    end
                end else if (roll < 9 && all_loaded(n)) begin
                    op = mhbik_pkg::OP_BUILD;
                    p  = $urandom_range(0, 2047);
                end else if (roll < 38) begin
                    op = mhbik_pkg::OP_LOAD;
                    p  = $urandom_range(1, n);
                end else begin
                    op = (roll < 68) ? mhbik_pkg::OP_INCR : mhbik_pkg::OP_READ;
                    p  = $urandom_range(1, n);
                    if (!path_loaded(p)) begin
                        p = $urandom_range(1, lim);
                    end
                    if (op == mhbik_pkg::OP_INCR && $urandom_range(0, 1) == 1) begin
                        key = 32'h7fff_ffff - $urandom_range(0, 255);
                    end
                end
                send_item(op, p[10:0], key);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
